FILE: hdl/rpl_pkg.sv
// Shared constants, types and helper functions of the reflector pair locator.
package rpl_pkg;

  localparam int MAX_SAMPLES  = 1024;
  localparam int CORDIC_STEPS = 16;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  localparam int RUN_W = 10;
  localparam logic [RUN_W-1:0] RUN_SAT = '1;
  localparam logic [RUN_W-1:0] RUN_PAIR = RUN_W'(2);

  localparam int DATA_W = 16;
  localparam int ANG_W  = 32;
  localparam int STEPA_W = 31;
  localparam int MID_W  = 17;

  localparam int XY_W = 18;
  localparam int Z_W  = 33;
  localparam int ACC_W = 33;
  localparam int PROD_W = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(19898);
  localparam int Q15_MAX = 32767;
  localparam int MID_MAX = 65535;

  localparam logic [DATA_W-1:0] THRESHOLD_RESET = DATA_W'(8000);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = CFG_IDX_W'(2);

  localparam int ATAN_IDX_W = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ANGLE,
    S_ROTATE,
    S_MULT,
    S_ACCUM,
    S_EMIT
  } geom_state_e;

  typedef struct packed {
    logic [RUN_W-1:0] run_count;
    logic             pair;
    logic [IDX_W-1:0] centre_one;
    logic [IDX_W-1:0] centre_two;
  } scan_sum_t;

  typedef struct packed {
    logic [DATA_W-1:0]  threshold;
    logic [ANG_W-1:0]   start_angle;
    logic [STEPA_W-1:0] angle_step;
  } cfg_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [ANG_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_q15(input logic signed [XY_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > XY_W'(Q15_MAX)) begin
      r = DATA_W'(Q15_MAX);
    end else if (v < -XY_W'(Q15_MAX)) begin
      r = -DATA_W'(Q15_MAX);
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // floor((acc + 2^15) / 2^16), clipped to the output range
  function automatic logic signed [MID_W-1:0] round_mid(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]  t;
    logic signed [ACC_W-16:0] r;
    logic signed [MID_W-1:0] m;
    t = {acc[ACC_W-1], acc} + (ACC_W+1)'(32768);
    r = t[ACC_W:16];
    if (r > (ACC_W-15)'(MID_MAX)) begin
      m = MID_W'(MID_MAX);
    end else if (r < -(ACC_W-15)'(MID_MAX)) begin
      m = -MID_W'(MID_MAX);
    end else begin
      m = r[MID_W-1:0];
    end
    return m;
  endfunction

endpackage

FILE: hdl/rpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rpl_scan.sv
// Per-sample front end: range store writes, run tracking and scan summary.
module rpl_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [rpl_pkg::DATA_W-1:0]    intensity_i,
  input  logic [rpl_pkg::DATA_W-1:0]    range_mm_i,
  input  logic                          last_i,
  input  logic [rpl_pkg::DATA_W-1:0]    threshold_i,
  output logic                          ram_we_o,
  output logic [rpl_pkg::IDX_W-1:0]     ram_addr_o,
  output logic [rpl_pkg::DATA_W-1:0]    ram_wdata_o,
  output logic                          done_o,
  output rpl_pkg::scan_sum_t            sum_o
);

  logic [rpl_pkg::CNT_W-1:0] sample_index_q, sample_index_d;
  logic                      run_active_q, run_active_d;
  logic [rpl_pkg::IDX_W-1:0] run_first_q, run_first_d;
  logic [rpl_pkg::IDX_W-1:0] run_last_q, run_last_d;
  logic [rpl_pkg::RUN_W-1:0] runs_q, runs_d;
  logic [rpl_pkg::IDX_W-1:0] centre_one_q, centre_one_d;
  logic [rpl_pkg::IDX_W-1:0] centre_two_q, centre_two_d;

  logic                      in_cap;
  logic [rpl_pkg::IDX_W-1:0] idx;
  logic                      hit;
  logic                      close;
  logic [rpl_pkg::IDX_W-1:0] close_first, close_last;
  logic [rpl_pkg::IDX_W:0]   csum;
  logic [rpl_pkg::IDX_W-1:0] centre;

  assign in_cap = sample_index_q < rpl_pkg::CNT_W'(rpl_pkg::MAX_SAMPLES);
  assign idx    = sample_index_q[rpl_pkg::IDX_W-1:0];
  assign hit    = intensity_i >= threshold_i;

  always_comb begin
    run_active_d = run_active_q;
    run_first_d  = run_first_q;
    run_last_d   = run_last_q;
    close        = 1'b0;
    close_first  = run_first_q;
    close_last   = run_last_q;
    if (in_cap) begin
      if (hit) begin
        if (!run_active_q) begin
          run_first_d = idx;
        end
        run_last_d   = idx;
        run_active_d = 1'b1;
      end else begin
        close        = run_active_q;
        run_active_d = 1'b0;
      end
    end
    // open run is closed on the final sample
    if (last_i && run_active_d) begin
      close       = 1'b1;
      close_first = run_first_d;
      close_last  = run_last_d;
    end
  end

  assign csum   = {1'b0, close_first} + {1'b0, close_last};
  assign centre = csum[rpl_pkg::IDX_W:1];

  always_comb begin
    runs_d       = runs_q;
    centre_one_d = centre_one_q;
    centre_two_d = centre_two_q;
    if (close && (close_first != close_last)) begin
      if (runs_q == '0) begin
        centre_one_d = centre;
      end else if (runs_q == rpl_pkg::RUN_W'(1)) begin
        centre_two_d = centre;
      end
      if (runs_q != rpl_pkg::RUN_SAT) begin
        runs_d = runs_q + rpl_pkg::RUN_W'(1);
      end
    end
  end

  assign sample_index_d = sample_index_q + rpl_pkg::CNT_W'(in_cap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      run_active_q   <= 1'b0;
      run_first_q    <= '0;
      run_last_q     <= '0;
      runs_q         <= '0;
      centre_one_q   <= '0;
      centre_two_q   <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        sample_index_q <= '0;
        run_active_q   <= 1'b0;
        run_first_q    <= '0;
        run_last_q     <= '0;
        runs_q         <= '0;
        centre_one_q   <= '0;
        centre_two_q   <= '0;
      end else begin
        sample_index_q <= sample_index_d;
        run_active_q   <= run_active_d;
        run_first_q    <= run_first_d;
        run_last_q     <= run_last_d;
        runs_q         <= runs_d;
        centre_one_q   <= centre_one_d;
        centre_two_q   <= centre_two_d;
      end
    end
  end

  assign ram_we_o    = accept_i && in_cap;
  assign ram_addr_o  = idx;
  assign ram_wdata_o = range_mm_i;

  assign done_o           = accept_i && last_i;
  assign sum_o.run_count  = runs_d;
  assign sum_o.pair       = runs_d == rpl_pkg::RUN_PAIR;
  assign sum_o.centre_one = centre_one_d;
  assign sum_o.centre_two = centre_two_d;

`ifndef SYNTHESIS
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_index_q <= rpl_pkg::CNT_W'(rpl_pkg::MAX_SAMPLES))
    else $error("sample index beyond capacity");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_active_q |-> (run_first_q <= run_last_q))
    else $error("open run has first index after last index");
`endif

endmodule

FILE: hdl/rpl_geom.sv
// End-of-scan engine: with a pair, reads two ranges, iterative CORDIC, midpoint; output word.
module rpl_geom (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  rpl_pkg::scan_sum_t                sum_i,
  input  logic [rpl_pkg::ANG_W-1:0]         start_angle_i,
  input  logic [rpl_pkg::STEPA_W-1:0]       angle_step_i,
  output logic                              idle_o,
  output logic                              ram_re_o,
  output logic [rpl_pkg::IDX_W-1:0]         ram_addr_o,
  input  logic [rpl_pkg::DATA_W-1:0]        ram_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rpl_pkg::RUN_W-1:0]         run_count_o,
  output logic                              pair_found_o,
  output logic signed [rpl_pkg::MID_W-1:0]  mid_x_o,
  output logic signed [rpl_pkg::MID_W-1:0]  mid_y_o
);

  rpl_pkg::geom_state_e state_q, state_d;

  rpl_pkg::scan_sum_t               sum_q;
  logic                             point_q;
  logic [rpl_pkg::ANG_W-1:0]        prod_q;
  logic [rpl_pkg::DATA_W-1:0]       range_q;
  logic                             flip_q;
  logic signed [rpl_pkg::XY_W-1:0]  x_q, y_q;
  logic signed [rpl_pkg::Z_W-1:0]   z_q;
  logic [rpl_pkg::STEP_W-1:0]       step_q;
  logic signed [rpl_pkg::PROD_W-1:0] mulx_q, muly_q;
  logic signed [rpl_pkg::ACC_W-1:0] accx_q, accy_q;

  logic                             out_valid_q;
  logic [rpl_pkg::RUN_W-1:0]        run_count_q;
  logic                             pair_q;
  logic signed [rpl_pkg::MID_W-1:0] mid_x_q, mid_y_q;

  logic                             load_out;
  logic                             slot_free;
  logic                             last_step;

  logic [rpl_pkg::IDX_W-1:0]                  cur_idx;
  logic [rpl_pkg::IDX_W+rpl_pkg::STEPA_W-1:0] ang_prod;
  logic [rpl_pkg::ANG_W-1:0]                  ang, ang_fold;
  logic                                       flip;
  logic signed [rpl_pkg::XY_W-1:0]            dx, dy, xs, ys;
  logic signed [rpl_pkg::Z_W-1:0]             atan_z;
  logic signed [rpl_pkg::DATA_W-1:0]          cos_v, sin_v;
  logic signed [rpl_pkg::DATA_W:0]            range_s;
  logic signed [2*rpl_pkg::DATA_W:0]          px, py;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_step = step_q == rpl_pkg::STEP_W'(rpl_pkg::CORDIC_STEPS - 1);
  assign cur_idx   = point_q ? sum_q.centre_two : sum_q.centre_one;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpl_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = sum_i.pair ? rpl_pkg::S_READ : rpl_pkg::S_EMIT;
        end
      end
      rpl_pkg::S_READ:   state_d = rpl_pkg::S_ANGLE;
      rpl_pkg::S_ANGLE:  state_d = rpl_pkg::S_ROTATE;
      rpl_pkg::S_ROTATE: begin
        if (last_step) begin
          state_d = rpl_pkg::S_MULT;
        end
      end
      rpl_pkg::S_MULT:   state_d = rpl_pkg::S_ACCUM;
      rpl_pkg::S_ACCUM:  state_d = point_q ? rpl_pkg::S_EMIT : rpl_pkg::S_READ;
      rpl_pkg::S_EMIT: begin
        if (slot_free) begin
          state_d = rpl_pkg::S_IDLE;
        end
      end
      default: state_d = rpl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idle_o   = 1'b0;
    ram_re_o = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      rpl_pkg::S_IDLE: idle_o   = 1'b1;
      rpl_pkg::S_READ: ram_re_o = 1'b1;
      rpl_pkg::S_EMIT: load_out = slot_free;
      default: begin
      end
    endcase
  end

  assign ram_addr_o = cur_idx;

  // bearing = start + index * step, folded into the right half-plane
  assign ang_prod = cur_idx * angle_step_i;
  assign ang      = start_angle_i + prod_q;
  assign flip     = ang[rpl_pkg::ANG_W-1] ^ ang[rpl_pkg::ANG_W-2];
  assign ang_fold = {ang[rpl_pkg::ANG_W-1] ^ flip, ang[rpl_pkg::ANG_W-2:0]};

  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_z = $signed({1'b0,
                  rpl_pkg::atan_turns(rpl_pkg::ATAN_IDX_W'(step_q))});

  assign xs      = flip_q ? -x_q : x_q;
  assign ys      = flip_q ? -y_q : y_q;
  assign cos_v   = rpl_pkg::sat_q15(xs);
  assign sin_v   = rpl_pkg::sat_q15(ys);
  assign range_s = $signed({1'b0, range_q});
  assign px      = range_s * cos_v;
  assign py      = range_s * sin_v;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rpl_pkg::S_IDLE: begin
        if (start_i) begin
          sum_q   <= sum_i;
          point_q <= 1'b0;
          accx_q  <= '0;
          accy_q  <= '0;
        end
      end
      rpl_pkg::S_READ: begin
        prod_q <= ang_prod[rpl_pkg::ANG_W-1:0];
      end
      rpl_pkg::S_ANGLE: begin
        range_q <= ram_rdata_i;
        flip_q  <= flip;
        x_q     <= rpl_pkg::CORDIC_GAIN;
        y_q     <= '0;
        z_q     <= {ang_fold[rpl_pkg::ANG_W-1], ang_fold};
        step_q  <= '0;
      end
      rpl_pkg::S_ROTATE: begin
        if (!z_q[rpl_pkg::Z_W-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_z;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_z;
        end
        step_q <= step_q + rpl_pkg::STEP_W'(1);
      end
      rpl_pkg::S_MULT: begin
        mulx_q <= px[rpl_pkg::PROD_W-1:0];
        muly_q <= py[rpl_pkg::PROD_W-1:0];
      end
      rpl_pkg::S_ACCUM: begin
        accx_q  <= accx_q + rpl_pkg::ACC_W'(mulx_q);
        accy_q  <= accy_q + rpl_pkg::ACC_W'(muly_q);
        point_q <= 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      run_count_q <= sum_q.run_count;
      pair_q      <= sum_q.pair;
      mid_x_q     <= sum_q.pair ? rpl_pkg::round_mid(accx_q) : '0;
      mid_y_q     <= sum_q.pair ? rpl_pkg::round_mid(accy_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_count_o  = run_count_q;
  assign pair_found_o = pair_q;
  assign mid_x_o      = mid_x_q;
  assign mid_y_o      = mid_y_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == rpl_pkg::S_IDLE))
    else $error("scan end while engine busy");

  a_no_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pair_q) |-> (mid_x_q == '0 && mid_y_q == '0))
    else $error("midpoint nonzero without a pair");
`endif

endmodule

FILE: hdl/reflector_pair_locator.sv
// Reflector pair locator top level: config registers, range store and engines.
// A word that is not last of scan is taken every cycle while the engine is idle, no result.
// Last word of scan without a pair: EMIT registers the result word once the output is free.
// With a pair: READ, ANGLE, ROTATE (iterative CORDIC), MULT, ACCUM per centre, then EMIT.
// in_ready_o is low from the last word of a scan until its result is registered.
// Reset (async, active low) clears scan state, resets config; range store is not cleared.
module reflector_pair_locator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rpl_pkg::ANG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rpl_pkg::DATA_W-1:0]          intensity_i,
  input  logic [rpl_pkg::DATA_W-1:0]          range_mm_i,
  input  logic                                last_of_scan_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rpl_pkg::RUN_W-1:0]           run_count_o,
  output logic                                pair_found_o,
  output logic signed [rpl_pkg::MID_W-1:0]    mid_x_o,
  output logic signed [rpl_pkg::MID_W-1:0]    mid_y_o
);

  rpl_pkg::cfg_t cfg_q;

  logic                        accept;
  logic                        idle;
  logic                        done;
  rpl_pkg::scan_sum_t          sum;
  logic                        ram_we;
  logic [rpl_pkg::IDX_W-1:0]   ram_waddr;
  logic [rpl_pkg::DATA_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [rpl_pkg::IDX_W-1:0]   ram_raddr;
  logic [rpl_pkg::DATA_W-1:0]  ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= rpl_pkg::THRESHOLD_RESET;
      cfg_q.start_angle <= '0;
      cfg_q.angle_step  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpl_pkg::CFG_THRESHOLD:   cfg_q.threshold   <= cfg_wdata_i[rpl_pkg::DATA_W-1:0];
        rpl_pkg::CFG_START_ANGLE: cfg_q.start_angle <= cfg_wdata_i;
        rpl_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_wdata_i[rpl_pkg::STEPA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = idle;
  assign accept     = in_valid_i && idle;

  rpl_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .intensity_i (intensity_i),
    .range_mm_i  (range_mm_i),
    .last_i      (last_of_scan_i),
    .threshold_i (cfg_q.threshold),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .done_o      (done),
    .sum_o       (sum)
  );

  rpl_ram #(
    .WIDTH (rpl_pkg::DATA_W),
    .DEPTH (rpl_pkg::MAX_SAMPLES)
  ) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpl_geom u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (done),
    .sum_i         (sum),
    .start_angle_i (cfg_q.start_angle),
    .angle_step_i  (cfg_q.angle_step),
    .idle_o        (idle),
    .ram_re_o      (ram_re),
    .ram_addr_o    (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .run_count_o   (run_count_o),
    .pair_found_o  (pair_found_o),
    .mid_x_o       (mid_x_o),
    .mid_y_o       (mid_y_o)
  );

endmodule

FILE: sim/reflector_pair_locator_tb.sv
// Testbench for reflector_pair_locator: scan stimulus, scan-result prediction and checking.
`timescale 1ns / 100ps

module reflector_pair_locator_tb;

  typedef struct {
    logic [rpl_pkg::RUN_W-1:0]        run_count;
    logic                             pair_found;
    logic signed [rpl_pkg::MID_W-1:0] mid_x;
    logic signed [rpl_pkg::MID_W-1:0] mid_y;
  } scan_report_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [rpl_pkg::CFG_IDX_W-1:0]    cfg_idx_i = rpl_pkg::CFG_THRESHOLD;
  logic [rpl_pkg::ANG_W-1:0]        cfg_wdata_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [rpl_pkg::DATA_W-1:0]       intensity_i = '0;
  logic [rpl_pkg::DATA_W-1:0]       range_mm_i = '0;
  logic                             last_of_scan_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [rpl_pkg::RUN_W-1:0]        run_count_o;
  logic                             pair_found_o;
  logic signed [rpl_pkg::MID_W-1:0] mid_x_o;
  logic signed [rpl_pkg::MID_W-1:0] mid_y_o;

  reflector_pair_locator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .intensity_i    (intensity_i),
    .range_mm_i     (range_mm_i),
    .last_of_scan_i (last_of_scan_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .run_count_o    (run_count_o),
    .pair_found_o   (pair_found_o),
    .mid_x_o        (mid_x_o),
    .mid_y_o        (mid_y_o)
  );

  // predicted block state
  logic [rpl_pkg::DATA_W-1:0]  thr_q = rpl_pkg::THRESHOLD_RESET;
  logic [rpl_pkg::ANG_W-1:0]   start_ang_q = '0;
  logic [rpl_pkg::STEPA_W-1:0] ang_step_q = '0;
  logic [rpl_pkg::DATA_W-1:0]  range_mem [rpl_pkg::MAX_SAMPLES];
  int                          scan_idx = 0;
  bit                          in_run = 1'b0;
  int                          run_lo = 0;
  int                          run_hi = 0;
  int                          runs = 0;
  int                          centre_a = 0;
  int                          centre_b = 0;

  longint       atan_tab [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  scan_report_t scan_reports [$];
  bit           scan_lit [$];
  int           mismatch_count = 0;
  int           word_count = 0;
  int           send_idle_pct = 9;
  int           recv_idle_pct = 58;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic longint clip(input longint v, input longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic void bearing_cos_sin(input logic [rpl_pkg::ANG_W-1:0] ang,
                                          output longint c, output longint s);
    logic [rpl_pkg::ANG_W-1:0] a;
    bit                        flip;
    longint                    x, y, z, dx, dy;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    a = flip ? ang - 32'h8000_0000 : ang;
    x = 19898;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < rpl_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, rpl_pkg::Q15_MAX);
    s = clip(y, rpl_pkg::Q15_MAX);
  endfunction

  function automatic void reflector_point(input int idx, output longint px, output longint py);
    logic [63:0] prod;
    longint      c, s, r;
    prod = 64'(idx) * 64'(ang_step_q);
    bearing_cos_sin(start_ang_q + prod[31:0], c, s);
    r = longint'(range_mem[idx]);
    px = r * c;
    py = r * s;
  endfunction

  function automatic logic signed [rpl_pkg::MID_W-1:0] midpoint_mm(input longint sum);
    return rpl_pkg::MID_W'(clip((sum + 32768) >>> 16, rpl_pkg::MID_MAX));
  endfunction

  function automatic void close_reflector_run();
    if (run_lo != run_hi) begin
      if (runs == 0) centre_a = (run_lo + run_hi) >> 1;
      else if (runs == 1) centre_b = (run_lo + run_hi) >> 1;
      if (runs < rpl_pkg::RUN_SAT) runs++;
    end
  endfunction

  function automatic void absorb_sample(input logic [rpl_pkg::DATA_W-1:0] inten,
                                        input logic [rpl_pkg::DATA_W-1:0] rng,
                                        input logic last);
    scan_report_t rep;
    longint       x1, y1, x2, y2;
    if (scan_idx < rpl_pkg::MAX_SAMPLES) begin
      range_mem[scan_idx] = rng;
      if (inten >= thr_q) begin
        if (!in_run) run_lo = scan_idx;
        run_hi = scan_idx;
        in_run = 1'b1;
      end else begin
        if (in_run) close_reflector_run();
        in_run = 1'b0;
      end
      scan_idx++;
    end
    if (last) begin
      if (in_run) close_reflector_run();
      rep.run_count = rpl_pkg::RUN_W'(runs);
      rep.pair_found = (runs == 2);
      rep.mid_x = '0;
      rep.mid_y = '0;
      if (runs == 2) begin
        reflector_point(centre_a, x1, y1);
        reflector_point(centre_b, x2, y2);
        rep.mid_x = midpoint_mm(x1 + x2);
        rep.mid_y = midpoint_mm(y1 + y2);
      end
      scan_reports.insert(scan_reports.size(), rep);
      scan_idx = 0; in_run = 1'b0; run_lo = 0; run_hi = 0;
      runs = 0; centre_a = 0; centre_b = 0;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    scan_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scan_reports.size() == 0) begin
        $display("%0t: expected no result, got run_count %0d", $time, run_count_o);
        mismatch_count++;
      end else begin
        want = scan_reports.pop_front();
        if (run_count_o !== want.run_count) begin
          $display("%0t: run_count expected %0d, got %0d", $time, want.run_count, run_count_o);
          mismatch_count++;
        end
        if (pair_found_o !== want.pair_found) begin
          $display("%0t: pair_found expected %0d, got %0d", $time, want.pair_found,
                   pair_found_o);
          mismatch_count++;
        end
        if (mid_x_o !== want.mid_x) begin
          $display("%0t: mid_x expected %0d, got %0d", $time, want.mid_x, mid_x_o);
          mismatch_count++;
        end
        if (mid_y_o !== want.mid_y) begin
          $display("%0t: mid_y expected %0d, got %0d", $time, want.mid_y, mid_y_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [rpl_pkg::DATA_W-1:0] sample_intensity(input bit lit);
    int pick;
    pick = $urandom_range(3);
    if (lit) begin
      if (pick == 0) return thr_q;
      if (pick == 1) return 16'hFFFF;
      return rpl_pkg::DATA_W'($urandom_range(65535, thr_q));
    end
    if (thr_q == 0) return rpl_pkg::DATA_W'($urandom);
    if (pick == 0) return thr_q - 1'b1;
    if (pick == 1) return '0;
    return rpl_pkg::DATA_W'($urandom_range(thr_q - 1, 0));
  endfunction

  function automatic logic [rpl_pkg::DATA_W-1:0] sample_range();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return 16'hFFFF;
    if (pick == 2) return '0;
    return rpl_pkg::DATA_W'($urandom);
  endfunction

  function automatic void fill_pattern(input string pat);
    scan_lit.delete();
    for (int i = 0; i < pat.len(); i++) scan_lit.insert(scan_lit.size(), pat[i] == "#");
  endfunction

  task automatic send_word(input logic [rpl_pkg::DATA_W-1:0] inten,
                           input logic [rpl_pkg::DATA_W-1:0] rng, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    intensity_i <= inten;
    range_mm_i <= rng;
    last_of_scan_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_sample(inten, rng, last);
    word_count++;
  endtask

  task automatic send_lit_scan();
    for (int i = 0; i < scan_lit.size(); i++) begin
      send_word(sample_intensity(scan_lit[i]), sample_range(), i == scan_lit.size() - 1);
    end
  endtask

  // hold the sender until every pending scan result is back and the engine has settled
  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (scan_reports.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rpl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpl_pkg::ANG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rpl_pkg::CFG_THRESHOLD:   thr_q = data[rpl_pkg::DATA_W-1:0];
      rpl_pkg::CFG_START_ANGLE: start_ang_q = data;
      rpl_pkg::CFG_ANGLE_STEP:  ang_step_q = data[rpl_pkg::STEPA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_defaults_and_edges();
    fill_pattern("#");
    send_lit_scan();
    fill_pattern("##.##");
    send_lit_scan();
    fill_pattern(".#.##.");
    send_lit_scan();
  endtask

  task automatic test_register_extremes();
    drain_results();
    write_reg(rpl_pkg::CFG_THRESHOLD, 32'h0);
    fill_pattern("....");
    send_lit_scan();
    drain_results();
    write_reg(rpl_pkg::CFG_THRESHOLD, 32'hFFFF);
    write_reg(rpl_pkg::CFG_START_ANGLE, 32'h7FFF_FFFF);
    write_reg(rpl_pkg::CFG_ANGLE_STEP, 32'h7FFF_FFFF);
    fill_pattern("##.##");
    send_lit_scan();
    drain_results();
    write_reg(rpl_pkg::CFG_START_ANGLE, 32'h8000_0000);
    write_reg(rpl_pkg::CFG_ANGLE_STEP, 32'hC000_0000);
    fill_pattern("##..##");
    send_lit_scan();
  endtask

  // a scan longer than the store; words past capacity are ignored but end the scan
  task automatic test_over_capacity();
    drain_results();
    write_reg(rpl_pkg::CFG_THRESHOLD, 32'd8000);
    write_reg(rpl_pkg::CFG_START_ANGLE, 32'hF000_0000);
    write_reg(rpl_pkg::CFG_ANGLE_STEP, 32'h0040_0000);
    scan_lit.delete();
    for (int i = 0; i < rpl_pkg::MAX_SAMPLES + 6; i++) begin
      if (i >= rpl_pkg::MAX_SAMPLES) begin
        scan_lit.insert(scan_lit.size(), bit'($urandom_range(1)));
      end else begin
        scan_lit.insert(scan_lit.size(), (i >= 5 && i <= 9) || i >= rpl_pkg::MAX_SAMPLES - 3);
      end
    end
    send_lit_scan();
  endtask

  task automatic build_random_scan();
    int kind;
    kind = $urandom_range(99);
    scan_lit.delete();
    if (kind < 65) begin
      repeat ($urandom_range(0, 4)) scan_lit.insert(scan_lit.size(), 1'b0);
      repeat ($urandom_range(2, 6)) scan_lit.insert(scan_lit.size(), 1'b1);
      repeat ($urandom_range(1, 4)) scan_lit.insert(scan_lit.size(), 1'b0);
      repeat ($urandom_range(2, 6)) scan_lit.insert(scan_lit.size(), 1'b1);
      repeat ($urandom_range(0, 3)) scan_lit.insert(scan_lit.size(), 1'b0);
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 6)) begin
        repeat ($urandom_range(1, 4)) scan_lit.insert(scan_lit.size(), 1'b1);
        repeat ($urandom_range(1, 3)) scan_lit.insert(scan_lit.size(), 1'b0);
      end
    end else begin
      repeat ($urandom_range(1, 30)) scan_lit.insert(scan_lit.size(), bit'($urandom_range(1)));
    end
  endtask

  task automatic randomize_registers();
    int          pick;
    logic [31:0] thr;
    pick = $urandom_range(9);
    thr = {16'($urandom_range(65535)), 16'($urandom_range(60000, 1000))};
    if (pick == 0) thr[15:0] = '0;
    else if (pick == 1) thr[15:0] = 16'hFFFF;
    else if (pick == 2) thr[15:0] = 16'($urandom);
    drain_results();
    write_reg(rpl_pkg::CFG_THRESHOLD, thr);
    write_reg(rpl_pkg::CFG_START_ANGLE, $urandom);
    if ($urandom_range(1)) write_reg(rpl_pkg::CFG_ANGLE_STEP, $urandom_range(32'h00FF_FFFF, 0));
    else write_reg(rpl_pkg::CFG_ANGLE_STEP, $urandom);
  endtask

  task automatic test_random_scans();
    int scans;
    int target;
    scans = 0;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 58;
        recv_idle_pct = 9;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      target = word_count + 85;
      while (word_count < target) begin
        if (scans % 6 == 0) randomize_registers();
        build_random_scan();
        send_lit_scan();
        scans++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults_and_edges();
    test_register_extremes();
    test_over_capacity();
    test_random_scans();
    drain_results();
    if (scan_reports.size() != 0) begin
      $display("%0t: expected %0d more scan results, got none", $time, scan_reports.size());
      mismatch_count += scan_reports.size();
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/rpl_pkg.sv
hdl/rpl_ram.sv
hdl/rpl_scan.sv
hdl/rpl_geom.sv
hdl/reflector_pair_locator.sv
sim/reflector_pair_locator_tb.sv
